@@ hdl/tbhq_pkg.sv @@
// ============================================================================
// Tiered binary heap queue package
// Entry layout, operation and status codes, and the controller-to-datapath
// command and status records shared by the heap queue modules.
// ============================================================================
`default_nettype none

package tbhq_pkg;

    // Field widths of one heap entry.
    localparam int TIER_W     = 3;
    localparam int ID_W       = 16;
    localparam int ENTRY_W    = TIER_W + 3 * ID_W;
    localparam int OCC_W      = 6;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    // Stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;
    localparam int IN_PAD_W    = IN_TDATA_W - ENTRY_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OCC_W - ENTRY_W;

    // Tier given to an entry whose user is promoted.
    localparam logic [TIER_W-1:0] TIER_PROMOTED = 3'd1;

    // The first member sits in the highest bits, so tier, the last member, is in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0]   handle;
        logic [ID_W-1:0]   user_id;
        logic [ID_W-1:0]   request_id;
        logic [TIER_W-1:0] tier;
    } t_entry;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH    = 2'd0,
        MODE_POP     = 2'd1,
        MODE_PROMOTE = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_PUSH_INIT,
        DP_POP_INIT,
        DP_POP_LOAD,
        DP_SCAN_INIT,
        DP_SCAN_READ,
        DP_SCAN_CMP,
        DP_UP_READ,
        DP_UP_CMP,
        DP_DN_READ,
        DP_DN_CMP,
        DP_PLACE,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    status_we;
        t_status status_code;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  at_root;
        logic  up_swap;
        logic  dn_leaf;
        logic  dn_swap;
        logic  scan_hit;
        logic  scan_last;
        logic  out_free;
    } t_dp_flags;

    // True when entry a is served strictly before entry b.
    function automatic logic entry_better(input t_entry a, input t_entry b);
        logic tier_lt;
        logic tier_eq;
        tier_lt = a.tier < b.tier;
        tier_eq = a.tier == b.tier;
        return tier_lt || (tier_eq && (a.request_id < b.request_id));
    endfunction

endpackage

`default_nettype wire

@@ hdl/tiered_binary_heap_queue.sv @@
// ============================================================================
// Tiered binary heap queue
// Priority queue of requests kept as a binary heap in a single memory,
// ordered by tier code and then by request id.
// ============================================================================
// Each slave transfer carries one command (tuser: push, pop, promote or no-op)
// and yields one master transfer: status in tuser, popped entry and occupancy
// in tdata, entry fields zero unless a pop succeeded. One command is worked on
// at a time; s_axis_tready is high only while the controller is idle. A push
// sifts the new entry up one heap level at a time until it stops or reaches
// the root; a pop takes the root, moves the last entry there and sifts it down
// until it stops or reaches a leaf; a promote scans the entries for the user,
// sets the match to the promoted tier and sifts it up. A full push, an empty
// pop and a no-op go straight to the result; a promote that finds no match
// ends after the scan. The controller returns to idle once the result loads
// and takes the next command from there. Reset empties the queue and drops a
// pending result without clearing the memory. A stalled result holds in the
// output register; one more command may be taken meanwhile and loads once
// the held result transfers.
// ============================================================================
`default_nettype none

module tiered_binary_heap_queue import tbhq_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: tier[2:0], request_id[18:3], user_id[34:19],
    //        payload_handle[50:35], zero padding[55:51]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [MODE_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: out_tier[2:0], out_request_id[18:3], out_user_id[34:19],
    //        out_handle[50:35], occupancy[56:51], zero padding[63:57]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: status[1:0]
    output logic [STATUS_W-1:0]         m_axis_tuser
);

    t_dp_cmd   w_cmd;
    t_dp_flags w_flags;

    // The controller steps through one heap level or scanned entry at a time.
    tbhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_flags    (w_flags),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath owns the heap memory, the count and the result register.
    tbhq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .i_cmd      (w_cmd),
        .o_flags    (w_flags),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ hdl/tbhq_dpath.sv @@
// ============================================================================
// Tiered binary heap queue datapath
// Heap memory with two registered read ports, the moving entry, the cursor,
// the entry count and the output register stage.
// ============================================================================
`default_nettype none

module tbhq_dpath import tbhq_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [MODE_W-1:0]      i_s_tuser,
    input  wire logic                   i_m_tready,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_flags                   o_flags,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [STATUS_W-1:0]         o_m_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = AW + 2;

    t_entry                 r_mem [CAPACITY];
    t_entry                 r_rd_a;
    t_entry                 r_rd_b;
    t_entry                 r_ent;
    t_entry                 r_in;
    t_entry                 r_pop;
    t_mode                  r_mode;
    t_status                r_status;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_pos;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [STATUS_W-1:0]    r_out_tuser;

    logic [AW-1:0] w_pos_m1;
    logic [AW-1:0] w_parent;
    logic [AW-1:0] w_count_m1;
    logic [PW-1:0] w_left;
    logic [PW-1:0] w_right;
    logic [PW-1:0] w_count_x;
    logic [PW-1:0] w_pos_inc;
    logic          w_right_ok;
    logic          w_pick_right;
    t_entry        w_pick;
    logic [AW-1:0] w_pick_idx;
    logic          w_up_swap;
    logic          w_dn_swap;
    t_entry        w_promoted;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr_a;
    logic [AW-1:0] w_rd_addr_b;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;

    assign w_pos_m1   = r_pos - AW'(1);
    assign w_parent   = w_pos_m1 >> 1;
    assign w_count_m1 = AW'(r_count - CW'(1));
    assign w_left     = (PW'(r_pos) << 1) | PW'(1);
    assign w_right    = w_left + PW'(1);
    assign w_count_x  = PW'(r_count);
    assign w_pos_inc  = PW'(r_pos) + PW'(1);

    assign w_right_ok   = w_right < w_count_x;
    assign w_pick_right = w_right_ok && entry_better(r_rd_b, r_rd_a);
    assign w_pick       = w_pick_right ? r_rd_b : r_rd_a;
    assign w_pick_idx   = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_up_swap    = entry_better(r_ent, r_rd_a);
    assign w_dn_swap    = entry_better(w_pick, r_ent);

    always_comb begin
        w_promoted      = r_rd_a;
        w_promoted.tier = TIER_PROMOTED;
    end

    // Memory port selection for the current operation.
    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr_a = r_pos;
        w_rd_addr_b = r_pos;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_pos;
        w_wr_data   = r_ent;
        case (i_cmd.op)
            DP_POP_INIT: begin
                w_rd_en     = 1'b1;
                w_rd_addr_a = '0;
                w_rd_addr_b = w_count_m1;
            end
            DP_UP_READ: begin
                w_rd_en     = 1'b1;
                w_rd_addr_a = w_parent;
            end
            DP_DN_READ: begin
                w_rd_en     = 1'b1;
                w_rd_addr_a = w_left[AW-1:0];
                w_rd_addr_b = w_right[AW-1:0];
            end
            DP_SCAN_READ: begin
                w_rd_en = 1'b1;
            end
            DP_PLACE: begin
                w_wr_en = 1'b1;
            end
            DP_UP_CMP: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_up_swap ? r_rd_a : r_ent;
            end
            DP_DN_CMP: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_dn_swap ? w_pick : r_ent;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    // Control state: entry count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_PUSH_INIT: r_count <= r_count + CW'(1);
                DP_POP_INIT:  r_count <= r_count - CW'(1);
                default:      r_count <= r_count;
            endcase
            if (i_cmd.op == DP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status_code;
        end
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_mode   <= t_mode'(i_s_tuser);
                r_in     <= t_entry'(i_s_tdata[ENTRY_W-1:0]);
                r_pop    <= '0;
                r_status <= ST_OK;
            end
            DP_PUSH_INIT: begin
                r_ent <= r_in;
                r_pos <= AW'(r_count);
            end
            DP_POP_LOAD: begin
                r_pop <= r_rd_a;
                r_ent <= r_rd_b;
                r_pos <= '0;
            end
            DP_SCAN_INIT: begin
                r_pos <= '0;
            end
            DP_SCAN_CMP: begin
                if (r_rd_a.user_id == r_in.user_id) begin
                    r_ent <= w_promoted;
                end else begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            DP_UP_CMP: begin
                if (w_up_swap) begin
                    r_pos <= w_parent;
                end
            end
            DP_DN_CMP: begin
                if (w_dn_swap) begin
                    r_pos <= w_pick_idx;
                end
            end
            DP_FINISH: begin
                r_out_tdata <= {{OUT_PAD_W{1'b0}}, OCC_W'(r_count), r_pop};
                r_out_tuser <= r_status;
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    always_comb begin
        o_flags.mode      = r_mode;
        o_flags.full      = r_count == CW'(CAPACITY);
        o_flags.empty     = r_count == '0;
        o_flags.at_root   = r_pos == '0;
        o_flags.up_swap   = w_up_swap;
        o_flags.dn_leaf   = w_left >= w_count_x;
        o_flags.dn_swap   = w_dn_swap;
        o_flags.scan_hit  = r_rd_a.user_id == r_in.user_id;
        o_flags.scan_last = w_pos_inc >= w_count_x;
        o_flags.out_free  = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

`default_nettype wire

@@ hdl/tbhq_ctrl.sv @@
// ============================================================================
// Tiered binary heap queue controller
// Sequences capture, decode, sift-up, sift-down, user scan and result
// hand-off by issuing one datapath command per cycle.
// ============================================================================
`default_nettype none

module tbhq_ctrl import tbhq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s_tvalid,
    input  wire t_dp_flags i_flags,
    output logic           o_s_tready,
    output t_dp_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state           = r_state;
        o_cmd.op          = DP_NOP;
        o_cmd.status_we   = 1'b0;
        o_cmd.status_code = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_flags.mode)
                    MODE_PUSH: begin
                        if (i_flags.full) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_FULL;
                        end else begin
                            o_cmd.op = DP_PUSH_INIT;
                            n_state  = S_UP_RD;
                        end
                    end
                    MODE_POP: begin
                        if (i_flags.empty) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_EMPTY;
                        end else begin
                            o_cmd.op = DP_POP_INIT;
                            n_state  = S_POP_LD;
                        end
                    end
                    MODE_PROMOTE: begin
                        if (i_flags.empty) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = ST_NOTFOUND;
                        end else begin
                            o_cmd.op = DP_SCAN_INIT;
                            n_state  = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_UP_RD: begin
                if (i_flags.at_root) begin
                    o_cmd.op = DP_PLACE;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = DP_UP_READ;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.op = DP_UP_CMP;
                n_state  = i_flags.up_swap ? S_UP_RD : S_FINISH;
            end
            S_POP_LD: begin
                o_cmd.op = DP_POP_LOAD;
                n_state  = i_flags.empty ? S_FINISH : S_DN_RD;
            end
            S_DN_RD: begin
                if (i_flags.dn_leaf) begin
                    o_cmd.op = DP_PLACE;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = DP_DN_READ;
                    n_state  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                o_cmd.op = DP_DN_CMP;
                n_state  = i_flags.dn_swap ? S_DN_RD : S_FINISH;
            end
            S_SCAN_RD: begin
                o_cmd.op = DP_SCAN_READ;
                n_state  = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.op = DP_SCAN_CMP;
                if (i_flags.scan_hit) begin
                    n_state = S_UP_RD;
                end else if (i_flags.scan_last) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = ST_NOTFOUND;
                    n_state           = S_FINISH;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_FINISH: begin
                if (i_flags.out_free) begin
                    o_cmd.op = DP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = r_state == S_IDLE;

endmodule

`default_nettype wire
